@@ hw/rtl/hcmm_pkg.sv @@
// shared types, codes and constants of the height and curvature mask marker
`timescale 1ns / 1ps

package hcmm_pkg;

   localparam int MAX_SIDE_DEF    = 64;
   localparam int SAMPLE_BITS_DEF = 16;
   localparam int PCT_BITS        = 14;

   localparam logic [PCT_BITS-1:0] FULL_SCALE = 14'd10000;

   // request kinds
   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_EMIT = 1'b1;

   // register indexes
   localparam logic [2:0] REG_MARK_SELECT       = 3'd0;
   localparam logic [2:0] REG_INVERT_HEIGHT     = 3'd1;
   localparam logic [2:0] REG_HEIGHT_PERCENT    = 3'd2;
   localparam logic [2:0] REG_CURVATURE_PERCENT = 3'd3;
   localparam logic [2:0] REG_MERGE_MODE        = 3'd4;
   localparam logic [2:0] REG_COMBINE_MODE      = 3'd5;
   localparam logic [2:0] REG_COLUMNS           = 3'd6;
   localparam logic [2:0] REG_ROWS              = 3'd7;

   // mark_select codes
   localparam logic [1:0] MARK_NONE      = 2'd0;
   localparam logic [1:0] MARK_HEIGHT    = 2'd1;
   localparam logic [1:0] MARK_CURVATURE = 2'd2;
   localparam logic [1:0] MARK_BOTH      = 2'd3;

   // merge_mode codes
   localparam logic [1:0] MERGE_UNION     = 2'd0;
   localparam logic [1:0] MERGE_INTERSECT = 2'd1;

   // combine_mode codes
   localparam logic [1:0] COMBINE_UNION     = 2'd1;
   localparam logic [1:0] COMBINE_INTERSECT = 2'd2;

   typedef struct packed {
      logic [1:0]          mark_select;
      logic                invert_height;
      logic [PCT_BITS-1:0] height_percent;
      logic [PCT_BITS-1:0] curvature_percent;
      logic [1:0]          merge_mode;
      logic [1:0]          combine_mode;
      logic [6:0]          columns;
      logic [6:0]          rows;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_COMP,
      ST_DRAIN_A,
      ST_DRAIN_B,
      ST_EMIT_READ,
      ST_EMIT_MULT,
      ST_EMIT_OUT,
      ST_EMIT_NR
   } state_type;

   typedef struct packed {
      logic load;
      logic comp_run;
      logic set_ready;
      logic emit_read;
      logic emit_mult;
      logic out_load;
      logic out_nr;
   } cmd_type;

   typedef struct packed {
      logic frame_ready;
      logic load_last;
      logic comp_last;
      logic out_free;
   } stat_type;

endpackage

@@ hw/rtl/hcmm_ram.sv @@
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps

module hcmm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                                       clock,
   input  logic                                       we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                           wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                           rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ hw/rtl/hcmm_csr.sv @@
// configuration register file
`timescale 1ns / 1ps

module hcmm_csr (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wen,
   input  logic [2:0]            csr_addr,
   input  logic [hcmm_pkg::PCT_BITS-1:0] csr_wdata,
   output hcmm_pkg::cfg_type     cfg
);

   hcmm_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         case (csr_addr)
            hcmm_pkg::REG_MARK_SELECT:       cfg_in.mark_select       = csr_wdata[1:0];
            hcmm_pkg::REG_INVERT_HEIGHT:     cfg_in.invert_height     = csr_wdata[0];
            hcmm_pkg::REG_HEIGHT_PERCENT:    cfg_in.height_percent    = csr_wdata;
            hcmm_pkg::REG_CURVATURE_PERCENT: cfg_in.curvature_percent = csr_wdata;
            hcmm_pkg::REG_MERGE_MODE:        cfg_in.merge_mode        = csr_wdata[1:0];
            hcmm_pkg::REG_COMBINE_MODE:      cfg_in.combine_mode      = csr_wdata[1:0];
            hcmm_pkg::REG_COLUMNS:           cfg_in.columns           = csr_wdata[6:0];
            hcmm_pkg::REG_ROWS:              cfg_in.rows              = csr_wdata[6:0];
            default:                         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mark_select       <= hcmm_pkg::MARK_HEIGHT;
         cfg_ff.invert_height     <= 1'b0;
         cfg_ff.height_percent    <= 14'd5000;
         cfg_ff.curvature_percent <= 14'd5000;
         cfg_ff.merge_mode        <= hcmm_pkg::MERGE_UNION;
         cfg_ff.combine_mode      <= 2'd0;
         cfg_ff.columns           <= 7'd64;
         cfg_ff.rows              <= 7'd64;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ hw/rtl/hcmm_ctrl.sv @@
// controller state machine sequencing load, compute pass and emit
`timescale 1ns / 1ps

module hcmm_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   input  logic               req_type,
   input  hcmm_pkg::stat_type stat,
   output logic               req_tready,
   output hcmm_pkg::cmd_type  cmd
);

   hcmm_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         hcmm_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               if (req_type == hcmm_pkg::REQ_LOAD) begin
                  if (!stat.frame_ready && stat.load_last) state_in = hcmm_pkg::ST_COMP;
               end else if (stat.frame_ready) begin
                  state_in = hcmm_pkg::ST_EMIT_READ;
               end else begin
                  state_in = hcmm_pkg::ST_EMIT_NR;
               end
            end
         end
         hcmm_pkg::ST_COMP:      if (stat.comp_last) state_in = hcmm_pkg::ST_DRAIN_A;
         hcmm_pkg::ST_DRAIN_A:   state_in = hcmm_pkg::ST_DRAIN_B;
         hcmm_pkg::ST_DRAIN_B:   state_in = hcmm_pkg::ST_IDLE;
         hcmm_pkg::ST_EMIT_READ: state_in = hcmm_pkg::ST_EMIT_MULT;
         hcmm_pkg::ST_EMIT_MULT: state_in = hcmm_pkg::ST_EMIT_OUT;
         hcmm_pkg::ST_EMIT_OUT:  if (stat.out_free) state_in = hcmm_pkg::ST_IDLE;
         hcmm_pkg::ST_EMIT_NR:   if (stat.out_free) state_in = hcmm_pkg::ST_IDLE;
         default:                state_in = hcmm_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready    = (state_ff == hcmm_pkg::ST_IDLE);
      cmd.load      = req_tready && req_tvalid && (req_type == hcmm_pkg::REQ_LOAD) &&
                      !stat.frame_ready;
      cmd.comp_run  = (state_ff == hcmm_pkg::ST_COMP);
      cmd.set_ready = (state_ff == hcmm_pkg::ST_DRAIN_B);
      cmd.emit_read = (state_ff == hcmm_pkg::ST_EMIT_READ);
      cmd.emit_mult = (state_ff == hcmm_pkg::ST_EMIT_MULT);
      cmd.out_nr    = (state_ff == hcmm_pkg::ST_EMIT_NR);
      cmd.out_load  = ((state_ff == hcmm_pkg::ST_EMIT_OUT) || cmd.out_nr) && stat.out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hcmm_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ hw/rtl/hcmm_datapath.sv @@
// datapath: frame stores, range tracking, laplacian pass, threshold tests, output register
`timescale 1ns / 1ps

module hcmm_datapath #(
   parameter int MAX_SIDE    = hcmm_pkg::MAX_SIDE_DEF,
   parameter int SAMPLE_BITS = hcmm_pkg::SAMPLE_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  hcmm_pkg::cfg_type      cfg,
   input  hcmm_pkg::cmd_type      cmd,
   input  logic [SAMPLE_BITS-1:0] pixel_value,
   input  logic                   existing_mask_bit,
   input  logic                   rsp_tready,
   output hcmm_pkg::stat_type     stat,
   output logic                   rsp_tvalid,
   output logic                   mask_bit,
   output logic                   last_pixel,
   output logic                   not_ready
);

   localparam int CAP  = MAX_SIDE * MAX_SIDE;
   localparam int AW   = (CAP > 1) ? $clog2(CAP) : 1;
   localparam int CW   = $clog2(CAP + 1);
   localparam int SW   = $clog2(MAX_SIDE + 1);
   localparam int LW   = SAMPLE_BITS + 3;
   localparam int HDW  = SAMPLE_BITS + 1;
   localparam int LDW  = LW + 1;
   localparam int HPW  = HDW + hcmm_pkg::PCT_BITS + 1;
   localparam int LPW  = LDW + hcmm_pkg::PCT_BITS + 1;

   localparam logic [2:0] TAP_UP    = 3'd0;
   localparam logic [2:0] TAP_DOWN  = 3'd1;
   localparam logic [2:0] TAP_LEFT  = 3'd2;
   localparam logic [2:0] TAP_RIGHT = 3'd3;
   localparam logic [2:0] TAP_CTR   = 3'd4;

   // frame size
   logic [SW-1:0] nc, nr;
   logic [CW-1:0] total;

   always_comb begin
      if (cfg.columns == 7'd0)                nc = SW'(1);
      else if (32'(cfg.columns) > 32'(MAX_SIDE)) nc = SW'(MAX_SIDE);
      else                                    nc = SW'(cfg.columns);
      if (cfg.rows == 7'd0)                   nr = SW'(1);
      else if (32'(cfg.rows) > 32'(MAX_SIDE)) nr = SW'(MAX_SIDE);
      else                                    nr = SW'(cfg.rows);
      total = CW'((2 * SW)'(nc) * (2 * SW)'(nr));
   end

   // counters and ranges
   logic [CW-1:0]                 load_count_ff;
   logic [AW-1:0]                 read_count_ff;
   logic                          frame_ready_ff;
   logic signed [SAMPLE_BITS-1:0] height_lo_ff, height_hi_ff;
   logic signed [LW-1:0]          laplace_lo_ff, laplace_hi_ff;
   logic                          emit_last;

   assign emit_last = ((CW + 1)'(read_count_ff) + (CW + 1)'(1)) >= (CW + 1)'(total);

   // compute pass walk
   logic [SW-1:0] row_ff, col_ff;
   logic [2:0]    tap_ff;
   logic [AW-1:0] row_base_ff;
   logic [AW-1:0] up_base, down_base, comp_addr, ctr_addr;
   logic [SW-1:0] col_l, col_r, col_sel;
   logic          col_end, row_end;

   always_comb begin
      col_end   = ((SW + 1)'(col_ff) + (SW + 1)'(1)) >= (SW + 1)'(nc);
      row_end   = ((SW + 1)'(row_ff) + (SW + 1)'(1)) >= (SW + 1)'(nr);
      col_l     = (col_ff != '0) ? col_ff - SW'(1) : col_ff;
      col_r     = col_end ? col_ff : col_ff + SW'(1);
      up_base   = (row_ff != '0) ? AW'((AW + 1)'(row_base_ff) - (AW + 1)'(nc)) : row_base_ff;
      down_base = row_end ? row_base_ff : AW'((AW + 1)'(row_base_ff) + (AW + 1)'(nc));
      ctr_addr  = AW'((AW + 1)'(row_base_ff) + (AW + 1)'(col_ff));
      case (tap_ff)
         TAP_UP:    comp_addr = AW'((AW + 1)'(up_base) + (AW + 1)'(col_ff));
         TAP_DOWN:  comp_addr = AW'((AW + 1)'(down_base) + (AW + 1)'(col_ff));
         TAP_LEFT:  comp_addr = AW'((AW + 1)'(row_base_ff) + (AW + 1)'(col_l));
         TAP_RIGHT: comp_addr = AW'((AW + 1)'(row_base_ff) + (AW + 1)'(col_r));
         default:   comp_addr = ctr_addr;
      endcase
      col_sel = col_ff;
   end

   always_ff @(posedge clock) begin
      if (!cmd.comp_run) begin
         row_ff      <= '0;
         col_ff      <= '0;
         tap_ff      <= TAP_UP;
         row_base_ff <= '0;
      end else if (tap_ff == TAP_CTR) begin
         tap_ff <= TAP_UP;
         if (col_end) begin
            col_ff <= '0;
            if (!row_end) begin
               row_ff      <= row_ff + SW'(1);
               row_base_ff <= AW'((AW + 1)'(row_base_ff) + (AW + 1)'(nc));
            end
         end else begin
            col_ff <= col_sel + SW'(1);
         end
      end else begin
         tap_ff <= tap_ff + 3'd1;
      end
   end

   // memories
   logic [SAMPLE_BITS-1:0] smp_rdata;
   logic [LW-1:0]          lap_rdata;
   logic                   prior_rdata;
   logic [AW-1:0]          smp_raddr;
   logic                   lap_vld_ff;
   logic signed [LW-1:0]   lap_ff;
   logic [AW-1:0]          lap_addr_ff;

   assign smp_raddr = cmd.comp_run ? comp_addr : read_count_ff;

   hcmm_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(CAP)) u_sample_ram (
      .clock (clock),
      .we    (cmd.load),
      .waddr (load_count_ff[AW-1:0]),
      .wdata (pixel_value),
      .raddr (smp_raddr),
      .rdata (smp_rdata)
   );

   hcmm_ram #(.WIDTH(LW), .DEPTH(CAP)) u_laplace_ram (
      .clock (clock),
      .we    (lap_vld_ff),
      .waddr (lap_addr_ff),
      .wdata (lap_ff),
      .raddr (read_count_ff),
      .rdata (lap_rdata)
   );

   hcmm_ram #(.WIDTH(1), .DEPTH(CAP)) u_prior_ram (
      .clock (clock),
      .we    (cmd.load),
      .waddr (load_count_ff[AW-1:0]),
      .wdata (existing_mask_bit),
      .raddr (read_count_ff),
      .rdata (prior_rdata)
   );

   // laplacian accumulation: data of a tap arrives in the cycle after its read
   logic                 dvld_ff;
   logic [2:0]           dtap_ff;
   logic [AW-1:0]        daddr_ff;
   logic signed [LW-1:0] acc_ff, dsx;

   assign dsx = LW'($signed(smp_rdata));

   always_ff @(posedge clock) begin
      dtap_ff  <= tap_ff;
      daddr_ff <= ctr_addr;
      if (dvld_ff) begin
         if (dtap_ff == TAP_UP) acc_ff <= dsx;
         else                   acc_ff <= acc_ff + dsx;
         lap_ff      <= acc_ff - (dsx <<< 2);
         lap_addr_ff <= daddr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dvld_ff    <= 1'b0;
         lap_vld_ff <= 1'b0;
      end else begin
         dvld_ff    <= cmd.comp_run;
         lap_vld_ff <= dvld_ff && (dtap_ff == TAP_CTR);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         laplace_lo_ff <= '0;
         laplace_hi_ff <= '0;
      end else if (lap_vld_ff) begin
         if (lap_addr_ff == '0) begin
            laplace_lo_ff <= lap_ff;
            laplace_hi_ff <= lap_ff;
         end else begin
            if (lap_ff < laplace_lo_ff) laplace_lo_ff <= lap_ff;
            if (lap_ff > laplace_hi_ff) laplace_hi_ff <= lap_ff;
         end
      end
   end

   // load side
   logic signed [SAMPLE_BITS-1:0] pv;
   assign pv = $signed(pixel_value);

   always_ff @(posedge clock) begin
      if (reset) begin
         height_lo_ff <= '0;
         height_hi_ff <= '0;
      end else if (cmd.load) begin
         if (load_count_ff == '0) begin
            height_lo_ff <= pv;
            height_hi_ff <= pv;
         end else begin
            if (pv < height_lo_ff) height_lo_ff <= pv;
            if (pv > height_hi_ff) height_hi_ff <= pv;
         end
      end
   end

   // emit threshold products
   logic signed [HDW-1:0] hd, hr;
   logic signed [LDW-1:0] ld, lr;
   logic signed [HPW-1:0] hl_ff, hr_ff;
   logic signed [LPW-1:0] ll_ff, lr_ff;
   logic                  prior_ff;

   always_comb begin
      hd = HDW'($signed(smp_rdata)) - HDW'(height_lo_ff);
      hr = HDW'(height_hi_ff) - HDW'(height_lo_ff);
      ld = LDW'($signed(lap_rdata)) - LDW'(laplace_lo_ff);
      lr = LDW'(laplace_hi_ff) - LDW'(laplace_lo_ff);
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_mult) begin
         hl_ff    <= HPW'($signed({1'b0, hcmm_pkg::FULL_SCALE})) * HPW'(hd);
         hr_ff    <= HPW'($signed({1'b0, cfg.height_percent})) * HPW'(hr);
         ll_ff    <= LPW'($signed({1'b0, hcmm_pkg::FULL_SCALE})) * LPW'(ld);
         lr_ff    <= LPW'($signed({1'b0, cfg.curvature_percent})) * LPW'(lr);
         prior_ff <= prior_rdata;
      end
   end

   // mark, merge and combine
   logic hm, cm, mark, final_mask;

   always_comb begin
      hm = (hl_ff >= hr_ff) ^ cfg.invert_height;
      cm = (ll_ff >= lr_ff);
      case (cfg.mark_select)
         hcmm_pkg::MARK_HEIGHT:    mark = hm;
         hcmm_pkg::MARK_CURVATURE: mark = cm;
         hcmm_pkg::MARK_BOTH: begin
            case (cfg.merge_mode)
               hcmm_pkg::MERGE_UNION:     mark = hm | cm;
               hcmm_pkg::MERGE_INTERSECT: mark = hm & cm;
               default:                   mark = hm;
            endcase
         end
         default: mark = 1'b0;
      endcase
      case (cfg.combine_mode)
         hcmm_pkg::COMBINE_UNION:     final_mask = mark | prior_ff;
         hcmm_pkg::COMBINE_INTERSECT: final_mask = mark & prior_ff;
         default:                     final_mask = mark;
      endcase
   end

   // counters, ready flag and output register
   logic rsp_tvalid_ff, mask_bit_ff, last_pixel_ff, not_ready_ff;
   logic out_done;

   assign out_done = cmd.out_load && !cmd.out_nr && emit_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         load_count_ff  <= '0;
         read_count_ff  <= '0;
         frame_ready_ff <= 1'b0;
         rsp_tvalid_ff  <= 1'b0;
      end else begin
         if (cmd.load) load_count_ff <= load_count_ff + CW'(1);
         if (cmd.set_ready) frame_ready_ff <= 1'b1;
         if (out_done) begin
            load_count_ff  <= '0;
            read_count_ff  <= '0;
            frame_ready_ff <= 1'b0;
         end else if (cmd.out_load && !cmd.out_nr) begin
            read_count_ff <= read_count_ff + AW'(1);
         end
         if (cmd.out_load)      rsp_tvalid_ff <= 1'b1;
         else if (rsp_tready)   rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         mask_bit_ff   <= !cmd.out_nr && final_mask;
         last_pixel_ff <= !cmd.out_nr && emit_last;
         not_ready_ff  <= cmd.out_nr;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign mask_bit   = mask_bit_ff;
   assign last_pixel = last_pixel_ff;
   assign not_ready  = not_ready_ff;

   always_comb begin
      stat.frame_ready = frame_ready_ff;
      stat.load_last   = ((CW + 1)'(load_count_ff) + (CW + 1)'(1)) >= (CW + 1)'(total);
      stat.comp_last   = (tap_ff == TAP_CTR) && col_end && row_end;
      stat.out_free    = !rsp_tvalid_ff || rsp_tready;
   end

endmodule

@@ hw/rtl/height_curvature_mask_marker.sv @@
// top level of the height and curvature mask marker
`timescale 1ns / 1ps

// Loads a frame of rows x columns signed height samples, one load request
// per pixel in row-major order, each with a prior mask bit, tracking the
// height minimum and maximum as it goes. The load that completes the frame
// starts a compute pass that forms the 3x3 laplacian of every pixel (edge
// replicated) and its range; the pass reads the sample memory through its
// single read port, five reads per pixel, then passes the drain states
// DRAIN_A and DRAIN_B; during all of it no request is taken (configuration
// writes still are). Emit requests then read the final mask out in order,
// one result per emit, with tlast on the last pixel; after it the block is
// ready for a new frame. An emit steps through accept, memory read,
// threshold multiply and compare into the output register; an emit before
// the frame is complete skips the read and multiply and answers with
// the not-ready flag set in tuser. Loads sent while a finished frame waits
// are dropped. The output register lets the next request be taken while a
// result is still waiting on rsp_tready. The thresholds are exact integer
// tests: 10000*(v-lo) >= percent*(hi-lo), percent in hundredths of a percent.
module height_curvature_mask_marker #(
   parameter int MAX_SIDE    = hcmm_pkg::MAX_SIDE_DEF,
   parameter int SAMPLE_BITS = hcmm_pkg::SAMPLE_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   // request channel
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // [SAMPLE_BITS-1:0] pixel_value, [SAMPLE_BITS] existing_mask_bit, zero fill
   input  logic [((SAMPLE_BITS + 1 + 7) / 8) * 8 - 1:0] req_tdata,
   // [0] req_type
   input  logic                                  req_tuser,
   // result channel
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [0] mask_bit, [7:1] zero
   output logic [7:0]                            rsp_tdata,
   // last_pixel
   output logic                                  rsp_tlast,
   // [0] not_ready
   output logic                                  rsp_tuser,
   // configuration port
   input  logic                                  csr_wen,
   input  logic [2:0]                            csr_addr,
   input  logic [hcmm_pkg::PCT_BITS-1:0]         csr_wdata
);

   hcmm_pkg::cfg_type  cfg;
   hcmm_pkg::cmd_type  cmd;
   hcmm_pkg::stat_type stat;
   logic               mask_bit;

   // register file
   hcmm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // sequencer
   hcmm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_type   (req_tuser),
      .stat       (stat),
      .req_tready (req_tready),
      .cmd        (cmd)
   );

   // stores, laplacian pass and threshold logic
   hcmm_datapath #(
      .MAX_SIDE    (MAX_SIDE),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .cmd               (cmd),
      .pixel_value       (req_tdata[SAMPLE_BITS-1:0]),
      .existing_mask_bit (req_tdata[SAMPLE_BITS]),
      .rsp_tready        (rsp_tready),
      .stat              (stat),
      .rsp_tvalid        (rsp_tvalid),
      .mask_bit          (mask_bit),
      .last_pixel        (rsp_tlast),
      .not_ready         (rsp_tuser)
   );

   assign rsp_tdata = {7'd0, mask_bit};

endmodule

@@ verif/hcmm_checker.sv @@
// request/result checker with its own prediction of the mask marker
`timescale 1ns / 1ps

module hcmm_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [23:0] req_tdata,
   input  logic        req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,
   input  logic        rsp_tlast,
   input  logic        rsp_tuser,
   input  logic        csr_wen,
   input  logic [2:0]  csr_addr,
   input  logic [13:0] csr_wdata,
   output int          fail_count,
   output int          pending
);

   localparam int CAP = hcmm_pkg::MAX_SIDE_DEF * hcmm_pkg::MAX_SIDE_DEF;

   typedef struct packed {
      logic mask_bit;
      logic last_pixel;
      logic not_ready;
   } mask_result_type;

   mask_result_type mask_results_q[$];

   // shadow of the register file
   logic [1:0]                    mark_sel;
   logic                          inv_height;
   logic [hcmm_pkg::PCT_BITS-1:0] height_pct;
   logic [hcmm_pkg::PCT_BITS-1:0] curv_pct;
   logic [1:0]                    merge_sel;
   logic [1:0]                    combine_sel;
   logic [6:0]                    cols_reg;
   logic [6:0]                    rows_reg;

   // shadow of the frame state
   int   heights [CAP];
   int   laplace [CAP];
   logic priors  [CAP];
   int   loaded;
   int   emitted;
   int   h_lo, h_hi, l_lo, l_hi;
   logic ready;

   function automatic int side_of(logic [6:0] v);
      if (v == 0) return 1;
      if (v > hcmm_pkg::MAX_SIDE_DEF) return hcmm_pkg::MAX_SIDE_DEF;
      return int'(v);
   endfunction

   // exact relative threshold: 10000*(v-lo) >= pct*(hi-lo)
   function automatic bit over_level(int v, int lo, int hi,
                                     logic [hcmm_pkg::PCT_BITS-1:0] pct);
      longint lhs, rhs;
      lhs = longint'(hcmm_pkg::FULL_SCALE) * (longint'(v) - longint'(lo));
      rhs = longint'(pct) * (longint'(hi) - longint'(lo));
      return lhs >= rhs;
   endfunction

   task automatic build_laplacian();
      int nc, nr, ru, rd, cl, cr, lv;
      nc = side_of(cols_reg);
      nr = side_of(rows_reg);
      for (int r = 0; r < nr; r++) begin
         ru = (r > 0) ? r - 1 : r;
         rd = (r + 1 < nr) ? r + 1 : r;
         for (int c = 0; c < nc; c++) begin
            cl = (c > 0) ? c - 1 : c;
            cr = (c + 1 < nc) ? c + 1 : c;
            lv = heights[ru*nc+c] + heights[rd*nc+c] + heights[r*nc+cl]
                 + heights[r*nc+cr] - 4 * heights[r*nc+c];
            laplace[r*nc+c] = lv;
            if (r == 0 && c == 0) begin
               l_lo = lv;
               l_hi = lv;
            end else begin
               if (lv < l_lo) l_lo = lv;
               if (lv > l_hi) l_hi = lv;
            end
         end
      end
      ready = 1'b1;
   endtask

   task automatic predict_request(logic kind, logic signed [15:0] value, logic prior);
      int total;
      bit hm, cm, m;
      mask_result_type res;
      total = side_of(cols_reg) * side_of(rows_reg);
      if (kind == hcmm_pkg::REQ_LOAD) begin
         if (ready || loaded >= CAP) return;
         heights[loaded] = int'(value);
         priors[loaded]  = prior;
         if (loaded == 0) begin
            h_lo = int'(value);
            h_hi = int'(value);
         end else begin
            if (int'(value) < h_lo) h_lo = int'(value);
            if (int'(value) > h_hi) h_hi = int'(value);
         end
         loaded++;
         if (loaded >= total) build_laplacian();
         return;
      end
      if (!ready) begin
         res = '{mask_bit: 1'b0, last_pixel: 1'b0, not_ready: 1'b1};
         mask_results_q.push_back(res);
         return;
      end
      hm = over_level(heights[emitted], h_lo, h_hi, height_pct);
      cm = over_level(laplace[emitted], l_lo, l_hi, curv_pct);
      if (inv_height) hm = !hm;
      case (mark_sel)
         hcmm_pkg::MARK_HEIGHT:    m = hm;
         hcmm_pkg::MARK_CURVATURE: m = cm;
         hcmm_pkg::MARK_BOTH: begin
            if (merge_sel == hcmm_pkg::MERGE_UNION) m = hm || cm;
            else if (merge_sel == hcmm_pkg::MERGE_INTERSECT) m = hm && cm;
            else m = hm;
         end
         default:        m = 1'b0;
      endcase
      if (combine_sel == hcmm_pkg::COMBINE_UNION) m = m || priors[emitted];
      else if (combine_sel == hcmm_pkg::COMBINE_INTERSECT) m = m && priors[emitted];
      res.mask_bit   = m;
      res.last_pixel = (emitted + 1 >= total);
      res.not_ready  = 1'b0;
      mask_results_q.push_back(res);
      if (res.last_pixel) begin
         emitted = 0;
         loaded  = 0;
         ready   = 1'b0;
      end else begin
         emitted++;
      end
   endtask

   task automatic apply_write(logic [2:0] addr, logic [13:0] data);
      case (addr)
         hcmm_pkg::REG_MARK_SELECT:       mark_sel    = data[1:0];
         hcmm_pkg::REG_INVERT_HEIGHT:     inv_height  = data[0];
         hcmm_pkg::REG_HEIGHT_PERCENT:    height_pct  = data;
         hcmm_pkg::REG_CURVATURE_PERCENT: curv_pct    = data;
         hcmm_pkg::REG_MERGE_MODE:        merge_sel   = data[1:0];
         hcmm_pkg::REG_COMBINE_MODE:      combine_sel = data[1:0];
         hcmm_pkg::REG_COLUMNS:           cols_reg    = data[6:0];
         hcmm_pkg::REG_ROWS:              rows_reg    = data[6:0];
         default: ;
      endcase
   endtask

   always @(posedge clock) begin : watch
      mask_result_type want;
      if (reset) begin
         mark_sel    = hcmm_pkg::MARK_HEIGHT;
         inv_height  = 1'b0;
         height_pct  = 14'd5000;
         curv_pct    = 14'd5000;
         merge_sel   = hcmm_pkg::MERGE_UNION;
         combine_sel = 2'd0;
         cols_reg    = 7'd64;
         rows_reg    = 7'd64;
         loaded  = 0;
         emitted = 0;
         h_lo = 0; h_hi = 0; l_lo = 0; l_hi = 0;
         ready = 1'b0;
         fail_count = 0;
         mask_results_q.delete();
      end else begin
         // results first: a result never answers a request of the same edge
         if (rsp_tvalid && rsp_tready) begin
            if (mask_results_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: unexpected result data=%h last=%b user=%b",
                           $time, rsp_tdata, rsp_tlast, rsp_tuser);
            end else begin
               want = mask_results_q.pop_front();
               if (rsp_tdata !== {7'd0, want.mask_bit} || rsp_tlast !== want.last_pixel
                   || rsp_tuser !== want.not_ready) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("%0t: mismatch exp mask=%b last=%b nr=%b got data=%h last=%b nr=%b",
                              $time, want.mask_bit, want.last_pixel, want.not_ready,
                              rsp_tdata, rsp_tlast, rsp_tuser);
               end
            end
         end
         if (csr_wen) apply_write(csr_addr, csr_wdata);
         if (req_tvalid && req_tready)
            predict_request(req_tuser, req_tdata[15:0], req_tdata[16]);
      end
      pending = mask_results_q.size();
   end

endmodule

@@ verif/tb_top.sv @@
// stimulus and verdict for the height and curvature mask marker
`timescale 1ns / 1ps

module tb_top;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // [15:0] pixel_value, [16] existing_mask_bit, zero fill
   logic        req_tuser = 1'b0; // [0] req_type
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;        // [0] mask_bit, [7:1] zero
   logic        rsp_tlast;        // last_pixel
   logic        rsp_tuser;        // [0] not_ready
   logic        csr_wen = 1'b0;
   logic [2:0]  csr_addr = '0;
   logic [13:0] csr_wdata = '0;

   int fail_count;
   int pending;

   // idling knobs, in percent
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_left      = 0;   // long receiver hold-off, counted down per cycle
   int requests_sent  = 0;

   height_curvature_mask_marker dut (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tlast, .rsp_tuser,
      .csr_wen, .csr_addr, .csr_wdata
   );

   hcmm_checker u_checker (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tlast, .rsp_tuser,
      .csr_wen, .csr_addr, .csr_wdata,
      .fail_count, .pending
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // run limit, far above the slowest correct run
   initial begin
      #4000000;
      $display("RESULT: ERROR");
      $finish;
   end

   // result side: random stalls, or a long hold-off when one is armed
   initial begin
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // one request; returns in the step of its acceptance with tvalid still high
   task automatic send_request(logic kind, logic [15:0] value, logic prior);
      bit taken;
      if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {7'd0, prior, value};
      do begin
         @(negedge clock);
         taken = req_tready;
         @(posedge clock);
      end while (!taken);
      requests_sent++;
   endtask

   // sender pause until every expected result has come, then some slack
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_all(logic [1:0] mark, logic inv, logic [13:0] hp, logic [13:0] cp,
                            logic [1:0] merge, logic [1:0] comb, logic [6:0] nc,
                            logic [6:0] nr);
      logic [13:0] vals [8];
      vals = '{14'(mark), 14'(inv), hp, cp, 14'(merge), 14'(comb), 14'(nc), 14'(nr)};
      for (int i = 0; i < 8; i++) begin
         @(posedge clock);
         csr_wen   <= 1'b1;
         csr_addr  <= 3'(i);
         csr_wdata <= vals[i];
      end
      @(posedge clock);
      csr_wen <= 1'b0;
   endtask

   function automatic int clamp_side(logic [6:0] v);
      if (v == 0) return 1;
      if (v > hcmm_pkg::MAX_SIDE_DEF) return hcmm_pkg::MAX_SIDE_DEF;
      return int'(v);
   endfunction

   function automatic logic [15:0] pick_height(int style, logic [15:0] base);
      case (style)
         0: return 16'($urandom);
         1: return base;                                   // flat frame
         2: case ($urandom_range(3))                       // extremes
               0: return 16'h8000;
               1: return 16'h7fff;
               2: return 16'hffff;
               default: return 16'h0000;
            endcase
         default: return base + 16'($urandom_range(7));    // narrow range
      endcase
   endfunction

   // one frame: loads with an optional early emit, an optional dropped load,
   // then the full read-out, possibly under a long receiver hold-off
   task automatic run_frame(int pixels, int style, bit early, bit stray, bit hold);
      logic [15:0] base;
      int early_at;
      base = 16'($urandom);
      early_at = $urandom_range(pixels - 1);
      for (int i = 0; i < pixels; i++) begin
         if (early && i == early_at)
            send_request(hcmm_pkg::REQ_EMIT, 16'($urandom), 1'($urandom));
         send_request(hcmm_pkg::REQ_LOAD, pick_height(style, base), 1'($urandom));
      end
      // load while a finished frame waits: dropped
      if (stray) send_request(hcmm_pkg::REQ_LOAD, 16'($urandom), 1'($urandom));
      if (hold) hold_left = 400;
      for (int i = 0; i < pixels; i++)
         send_request(hcmm_pkg::REQ_EMIT, 16'($urandom), 1'($urandom));
   endtask

   function automatic logic [13:0] pick_percent();
      case ($urandom_range(5))
         0: return 14'd0;
         1: return 14'd10000;
         2: return 14'h3fff;  // above full scale
         default: return 14'($urandom_range(10000));
      endcase
   endfunction

   initial begin
      int phase;
      logic [6:0] nc, nr;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: emit before any frame, at reset settings
      send_request(hcmm_pkg::REQ_EMIT, 16'h0000, 1'b0);
      drain();

      // directed: 3x3 with extreme heights, early emit and a dropped load
      write_all(hcmm_pkg::MARK_BOTH, 1'b0, 14'd10000, 14'd0, hcmm_pkg::MERGE_UNION,
                hcmm_pkg::COMBINE_UNION, 7'd3, 7'd3);
      run_frame(9, 2, 1'b1, 1'b1, 1'b0);
      drain();

      // directed: zero sizes act as one pixel, intersection with prior mask
      write_all(hcmm_pkg::MARK_CURVATURE, 1'b1, 14'd0, 14'h3fff, hcmm_pkg::MERGE_INTERSECT,
                hcmm_pkg::COMBINE_INTERSECT, 7'd0, 7'd0);
      run_frame(1, 0, 1'b0, 1'b1, 1'b0);
      drain();

      // random phases, cycling through the idling modes
      phase = 0;
      while (requests_sent < 1950) begin
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
            default: begin send_idle_pct = 35; recv_stall_pct = 35; end
         endcase
         // mostly small frames; now and then a wide or tall strip
         case ($urandom_range(9))
            0: begin nc = 7'($urandom_range(2) == 0 ? 127 : 64); nr = 7'($urandom_range(2)); end
            1: begin nr = 7'($urandom_range(2) == 0 ? 127 : 64); nc = 7'($urandom_range(2)); end
            default: begin nc = 7'($urandom_range(6)); nr = 7'($urandom_range(6)); end
         endcase
         write_all(2'($urandom), 1'($urandom), pick_percent(), pick_percent(),
                   2'($urandom), 2'($urandom), nc, nr);
         repeat (1 + $urandom_range(2))
            run_frame(clamp_side(nc) * clamp_side(nr), $urandom_range(3),
                      $urandom_range(7) == 0, $urandom_range(3) == 0,
                      phase % 7 == 3);
         drain();
         phase++;
      end

      repeat (40) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
